/* rtl/core/atmt_pkg.sv */
package atmt_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int HOUR_W = 5;
  localparam int MIN_W = 6;
  localparam int TOD_W = 11;
  localparam int STAMP_W = 32;

  localparam logic [TOD_W-1:0] DAY_MIN = TOD_W'(1440);
  localparam logic [STAMP_W-1:0] STAMP_NONE = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                mode;
    logic [2:0]          entry_index;
    logic                entry_active;
    logic [HOUR_W-1:0]   entry_hour;
    logic [MIN_W-1:0]    entry_minute;
    logic [HOUR_W-1:0]   now_hour;
    logic [MIN_W-1:0]    now_minute;
    logic [STAMP_W-1:0]  minute_stamp;
    logic                alarm_busy;
    logic                queue_ready;
  } item_t;

  typedef struct packed {
    logic                trigger_valid;
    logic [2:0]          trigger_index;
    logic                next_found;
    logic [HOUR_W-1:0]   next_hour;
    logic [MIN_W-1:0]    next_minute;
  } result_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_full;
  } sts_t;

  // time of day in minutes, folded into 0..1439 (raw value never exceeds 1923)
  function automatic logic [TOD_W-1:0] day_tod(input logic [HOUR_W-1:0] h,
                                                input logic [MIN_W-1:0] m);
    logic [TOD_W-1:0] raw;
    raw = {h, 6'b0} - {4'b0, h, 2'b0} + {5'b0, m};
    return (raw >= DAY_MIN) ? raw - DAY_MIN : raw;
  endfunction

endpackage

/* rtl/core/atmt_in_if.sv */
interface atmt_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [2:0]  entry_index;
  logic        entry_active;
  logic [4:0]  entry_hour;
  logic [5:0]  entry_minute;
  logic [4:0]  now_hour;
  logic [5:0]  now_minute;
  logic [31:0] minute_stamp;
  logic        alarm_busy;
  logic        queue_ready;

  modport source (
    output valid, mode, entry_index, entry_active, entry_hour, entry_minute,
           now_hour, now_minute, minute_stamp, alarm_busy, queue_ready,
    input  ready
  );
  modport sink (
    input  valid, mode, entry_index, entry_active, entry_hour, entry_minute,
           now_hour, now_minute, minute_stamp, alarm_busy, queue_ready,
    output ready
  );
endinterface

/* rtl/core/atmt_out_if.sv */
interface atmt_out_if;
  logic       valid;
  logic       ready;
  logic       trigger_valid;
  logic [2:0] trigger_index;
  logic       next_found;
  logic [4:0] next_hour;
  logic [5:0] next_minute;

  modport source (
    output valid, trigger_valid, trigger_index, next_found, next_hour, next_minute,
    input  ready
  );
  modport sink (
    input  valid, trigger_valid, trigger_index, next_found, next_hour, next_minute,
    output ready
  );
endinterface

/* rtl/core/alarm_time_match_table_unit.sv */
// Sequence: a request accepted in idle is captured by load, then the scan reads the table
//   (one table entry scanned per cycle over 8 entries), then finish puts the result on the output.
// No new request is taken until finish; the scan uses the single table read port.
// The result waits in an output register; a stalled output holds the next finish back.
// Reset (asynchronous, active low): table entries inactive at 00:00, last fired stamp all ones.
module alarm_time_match_table_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  atmt_in_if.sink    in_i,
  atmt_out_if.source out_o
);

  atmt_pkg::cmd_t    cmd;
  atmt_pkg::sts_t    sts;
  atmt_pkg::item_t   item;
  atmt_pkg::result_t res;
  logic              in_ready;
  logic              out_valid;

  always_comb begin
    item.mode         = in_i.mode;
    item.entry_index  = in_i.entry_index;
    item.entry_active = in_i.entry_active;
    item.entry_hour   = in_i.entry_hour;
    item.entry_minute = in_i.entry_minute;
    item.now_hour     = in_i.now_hour;
    item.now_minute   = in_i.now_minute;
    item.minute_stamp = in_i.minute_stamp;
    item.alarm_busy   = in_i.alarm_busy;
    item.queue_ready  = in_i.queue_ready;
  end

  atmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  atmt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid;
  assign out_o.trigger_valid = res.trigger_valid;
  assign out_o.trigger_index = res.trigger_index;
  assign out_o.next_found    = res.next_found;
  assign out_o.next_hour     = res.next_hour;
  assign out_o.next_minute   = res.next_minute;

endmodule

/* rtl/core/atmt_ctrl.sv */
module atmt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  atmt_pkg::sts_t  sts_i,
  output atmt_pkg::cmd_t  cmd_o
);

  atmt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atmt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      atmt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = atmt_pkg::ST_SCAN;
        end
      end
      atmt_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = atmt_pkg::ST_FINISH;
        end
      end
      atmt_pkg::ST_FINISH: begin
        // hold the result back while the output register is still occupied
        if (!sts_i.out_full) begin
          cmd_o.finish = 1'b1;
          state_d      = atmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = atmt_pkg::ST_IDLE;
      end
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.scan, cmd_o.finish}))
    else $error("more than one datapath command at once");

  a_scan_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == atmt_pkg::ST_SCAN && sts_i.scan_last) |=> (state_q == atmt_pkg::ST_FINISH))
    else $error("scan end did not lead to finish");

endmodule

/* rtl/core/atmt_dpath.sv */
module atmt_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  atmt_pkg::cmd_t    cmd_i,
  output atmt_pkg::sts_t    sts_o,
  input  atmt_pkg::item_t   item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output atmt_pkg::result_t res_o
);

  localparam int IW = atmt_pkg::IDX_W;
  localparam int TW = atmt_pkg::TOD_W;

  // alarm table, with each entry's time of day kept alongside
  logic                        active_q [atmt_pkg::ENTRIES];
  logic [atmt_pkg::HOUR_W-1:0] hour_q   [atmt_pkg::ENTRIES];
  logic [atmt_pkg::MIN_W-1:0]  minute_q [atmt_pkg::ENTRIES];
  logic [TW-1:0]               tod_q    [atmt_pkg::ENTRIES];

  logic [atmt_pkg::STAMP_W-1:0] last_fired_q;
  logic [atmt_pkg::STAMP_W-1:0] stamp_q;
  logic                         check_en_q;
  logic                         queue_ready_q;
  logic [atmt_pkg::HOUR_W-1:0]  now_h_q;
  logic [atmt_pkg::MIN_W-1:0]   now_m_q;
  logic [TW-1:0]                now_tod_q;

  logic [IW-1:0]                scan_idx_q;
  logic                         hit_q;
  logic [IW-1:0]                hit_idx_q;
  logic                         found_q;
  logic [TW-1:0]                best_d_q;
  logic [atmt_pkg::HOUR_W-1:0]  best_h_q;
  logic [atmt_pkg::MIN_W-1:0]   best_m_q;

  logic                         out_valid_q;
  atmt_pkg::result_t            res_q;

  logic                         wr_en;
  logic [IW-1:0]                wr_idx;
  logic                         cur_active;
  logic [atmt_pkg::HOUR_W-1:0]  cur_hour;
  logic [atmt_pkg::MIN_W-1:0]   cur_minute;
  logic [TW-1:0]                cur_tod;
  logic [TW:0]                  diff;
  logic [TW-1:0]                fwd_dist;
  logic                         is_match;
  logic                         is_nearer;

  assign wr_en  = cmd_i.load && item_i.mode &&
                  (32'(item_i.entry_index) < atmt_pkg::ENTRIES);
  assign wr_idx = IW'(item_i.entry_index);

  assign cur_active = active_q[scan_idx_q];
  assign cur_hour   = hour_q[scan_idx_q];
  assign cur_minute = minute_q[scan_idx_q];
  assign cur_tod    = tod_q[scan_idx_q];

  // forward distance: wrap a negative difference by one day
  assign diff     = {1'b0, cur_tod} - {1'b0, now_tod_q};
  assign fwd_dist = diff[TW] ? diff[TW-1:0] + atmt_pkg::DAY_MIN : diff[TW-1:0];

  assign is_match  = check_en_q && !hit_q && cur_active &&
                     (cur_hour == now_h_q) && (cur_minute == now_m_q);
  assign is_nearer = cur_active && (fwd_dist < best_d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < atmt_pkg::ENTRIES; i++) begin
        active_q[i] <= 1'b0;
        hour_q[i]   <= '0;
        minute_q[i] <= '0;
        tod_q[i]    <= '0;
      end
    end else if (wr_en) begin
      active_q[wr_idx] <= item_i.entry_active;
      hour_q[wr_idx]   <= item_i.entry_hour;
      minute_q[wr_idx] <= item_i.entry_minute;
      tod_q[wr_idx]    <= atmt_pkg::day_tod(item_i.entry_hour, item_i.entry_minute);
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      stamp_q       <= item_i.minute_stamp;
      queue_ready_q <= item_i.queue_ready;
      now_h_q       <= item_i.now_hour;
      now_m_q       <= item_i.now_minute;
      now_tod_q     <= atmt_pkg::day_tod(item_i.now_hour, item_i.now_minute);
      check_en_q    <= !item_i.mode && !item_i.alarm_busy &&
                       (item_i.minute_stamp != last_fired_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      found_q    <= 1'b0;
      best_d_q   <= atmt_pkg::DAY_MIN;
      best_h_q   <= '0;
      best_m_q   <= '0;
    end else if (cmd_i.load) begin
      scan_idx_q <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      found_q    <= 1'b0;
      best_d_q   <= atmt_pkg::DAY_MIN;
      best_h_q   <= '0;
      best_m_q   <= '0;
    end else if (cmd_i.scan) begin
      scan_idx_q <= scan_idx_q + 1'b1;
      if (is_match) begin
        hit_q     <= 1'b1;
        hit_idx_q <= scan_idx_q;
      end
      if (is_nearer) begin
        found_q  <= 1'b1;
        best_d_q <= fwd_dist;
        best_h_q <= cur_hour;
        best_m_q <= cur_minute;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_fired_q <= atmt_pkg::STAMP_NONE;
    end else if (cmd_i.finish && hit_q && queue_ready_q) begin
      last_fired_q <= stamp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q.trigger_valid <= hit_q;
      res_q.trigger_index <= 3'(hit_idx_q);
      res_q.next_found    <= found_q;
      res_q.next_hour     <= best_h_q;
      res_q.next_minute   <= best_m_q;
    end
  end

  assign sts_o.scan_last = (scan_idx_q == IW'(atmt_pkg::ENTRIES - 1));
  assign sts_o.out_full  = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign res_o           = res_q;

  a_hit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> found_q)
    else $error("trigger hit without an active entry found");

  a_best_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q ? (best_d_q < atmt_pkg::DAY_MIN) : (best_d_q == atmt_pkg::DAY_MIN))
    else $error("nearest distance inconsistent with found flag");

  a_stamp_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(last_fired_q) |-> $past(cmd_i.finish && hit_q && queue_ready_q))
    else $error("last fired stamp changed without an accepted trigger");

endmodule
